FILE: hw/rtl/dhgm_pkg.sv
// shared constants, state encoding and status type for the depth histogram gray mapper
// no dependencies; used by dhgm_gray_div and depth_histogram_gray_mapper
package dhgm_pkg;

   localparam int DEPTH_BINS = 16384;
   localparam int BIN_AW     = $clog2(DEPTH_BINS);
   localparam int DEPTH_W    = 16;
   localparam int CNT_W      = 19;
   localparam int GRAY_W     = 8;
   localparam int STEP_W     = $clog2(GRAY_W);

   localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};
   localparam logic [GRAY_W-1:0] GRAY_MAX  = {GRAY_W{1'b1}};
   localparam logic [BIN_AW-1:0] BIN_LAST  = BIN_AW'(DEPTH_BINS - 1);
   localparam logic [BIN_AW-1:0] BIN_FIRST = BIN_AW'(1);

   localparam logic OP_ACCUMULATE = 1'b0;
   localparam logic OP_MAP        = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACC_RD,
      ST_ACC_WR,
      ST_BLD_RD,
      ST_BLD_SUM,
      ST_BLD_DIV,
      ST_BLD_WAIT,
      ST_MAP_RD,
      ST_MAP_OUT
   } state_type;

   typedef struct packed {
      logic              done;
      logic [GRAY_W-1:0] gray;
   } div_status_type;

endpackage

FILE: hw/rtl/dhgm_gray_div.sv
// bit-serial divider: gray = min(255, floor(256 * (n - cum) / n)), 0 when n is zero
// one shared compare-subtract unit, one quotient bit per cycle; uses dhgm_pkg
module dhgm_gray_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [dhgm_pkg::CNT_W-1:0] n,
   input  logic [dhgm_pkg::CNT_W-1:0] cum,
   output dhgm_pkg::div_status_type   status
);

   logic [dhgm_pkg::CNT_W-1:0]  rem_ff, rem_in;
   logic [dhgm_pkg::CNT_W-1:0]  n_ff, n_in;
   logic [dhgm_pkg::GRAY_W-1:0] q_ff, q_in;
   logic [dhgm_pkg::STEP_W-1:0] cnt_ff, cnt_in;
   logic                        active_ff, active_in;
   logic                        done_ff, done_in;

   logic [dhgm_pkg::CNT_W:0]    sub_a, sub_b, shifted;
   logic [dhgm_pkg::CNT_W+1:0]  diff;
   logic                        ge;

   // the one subtractor: n - cum on start, then shifted remainder - n per step
   assign shifted = {rem_ff, 1'b0};
   assign sub_a   = active_ff ? shifted : {1'b0, n};
   assign sub_b   = active_ff ? {1'b0, n_ff} : {1'b0, cum};
   assign diff    = {1'b0, sub_a} - {1'b0, sub_b};
   assign ge      = ~diff[dhgm_pkg::CNT_W+1];

   always_comb begin
      rem_in    = rem_ff;
      n_in      = n_ff;
      q_in      = q_ff;
      cnt_in    = cnt_ff;
      active_in = active_ff;
      done_in   = 1'b0;
      if (active_ff) begin
         rem_in = ge ? diff[dhgm_pkg::CNT_W-1:0] : shifted[dhgm_pkg::CNT_W-1:0];
         q_in   = {q_ff[dhgm_pkg::GRAY_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == dhgm_pkg::STEP_W'(dhgm_pkg::GRAY_W - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end else if (start) begin
         n_in   = n;
         cnt_in = '0;
         if (n == '0) begin
            q_in    = '0;
            done_in = 1'b1;
         end else if (cum == '0) begin
            // quotient would be 256, saturate
            q_in    = dhgm_pkg::GRAY_MAX;
            done_in = 1'b1;
         end else begin
            rem_in    = diff[dhgm_pkg::CNT_W-1:0];
            q_in      = '0;
            active_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      n_ff   <= n_in;
      q_ff   <= q_in;
      if (reset) begin
         cnt_ff    <= '0;
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   assign status.done = done_ff;
   assign status.gray = q_ff;

endmodule

FILE: hw/rtl/depth_histogram_gray_mapper.sv
// top level: depth histogram, cumulative equalization table and depth-to-gray lookup
// holds the bin memory and the sequencer; uses dhgm_pkg and dhgm_gray_div
//
//   channel   ports                                         direction  handshake
//   request   req_opcode, req_depth_sample, req_frame_end   in         start & !busy
//   response  rsp_gray_level, rsp_last_of_frame             out        rsp_valid, one cycle
//
// map beat: busy in MAP_RD and MAP_OUT after accept, rsp_valid registered from MAP_OUT.
// accumulate beat: ACC_RD, ACC_WR on a depth hit (read-modify-write of one bin in memory).
// first accumulate after a finished table: clears all DEPTH_BINS (16384) bins first.
// frame end: table build walks bins 1..DEPTH_BINS-1, steps per bin (memory read, clamp add,
//   divider start, 8-step divider), steps skipped while the sum is zero or the frame is empty.
// reset: clearing pass over all DEPTH_BINS bins with busy high; the receiver cannot stall.
module depth_histogram_gray_mapper (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_opcode,
   input  logic [dhgm_pkg::DEPTH_W-1:0]      req_depth_sample,
   input  logic                              req_frame_end,
   output logic                              rsp_valid,
   output logic [dhgm_pkg::GRAY_W-1:0]       rsp_gray_level,
   output logic                              rsp_last_of_frame
);

   dhgm_pkg::state_type state_ff, state_in;

   logic [dhgm_pkg::CNT_W-1:0] bin_mem [dhgm_pkg::DEPTH_BINS];
   logic [dhgm_pkg::CNT_W-1:0] rd_data_ff;
   logic                       mem_rd_en, mem_wr_en;
   logic [dhgm_pkg::BIN_AW-1:0] mem_rd_addr, mem_wr_addr;
   logic [dhgm_pkg::CNT_W-1:0] mem_wr_data;

   logic [dhgm_pkg::BIN_AW-1:0]  idx_ff, idx_in;
   logic                         pend_ff, pend_in;
   logic                         ready_ff, ready_in;
   logic [dhgm_pkg::CNT_W-1:0]   point_ff, point_in;
   logic [dhgm_pkg::CNT_W-1:0]   cum_ff, cum_in;
   logic [dhgm_pkg::DEPTH_W-1:0] depth_ff, depth_in;
   logic                         fend_ff, fend_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [dhgm_pkg::GRAY_W-1:0]  rsp_gray_ff, rsp_gray_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         accept;
   logic                         depth_hit;
   logic [dhgm_pkg::CNT_W:0]     sum;
   logic                         div_start;
   dhgm_pkg::div_status_type     div_status;

   assign busy      = (state_ff != dhgm_pkg::ST_IDLE);
   assign accept    = start & ~busy;
   assign depth_hit = (depth_ff != '0) &&
                      ({1'b0, depth_ff} < (dhgm_pkg::DEPTH_W+1)'(dhgm_pkg::DEPTH_BINS));
   assign sum       = {1'b0, cum_ff} + {1'b0, rd_data_ff};

   dhgm_gray_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .n      (point_ff),
      .cum    (cum_ff),
      .status (div_status)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dhgm_pkg::ST_CLEAR: begin
            if (idx_ff == dhgm_pkg::BIN_LAST) begin
               state_in = pend_ff ? dhgm_pkg::ST_ACC_RD : dhgm_pkg::ST_IDLE;
            end
         end
         dhgm_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_opcode == dhgm_pkg::OP_MAP) begin
                  state_in = dhgm_pkg::ST_MAP_RD;
               end else if (ready_ff) begin
                  state_in = dhgm_pkg::ST_CLEAR;
               end else begin
                  state_in = dhgm_pkg::ST_ACC_RD;
               end
            end
         end
         dhgm_pkg::ST_ACC_RD: begin
            if (depth_hit) begin
               state_in = dhgm_pkg::ST_ACC_WR;
            end else begin
               state_in = fend_ff ? dhgm_pkg::ST_BLD_RD : dhgm_pkg::ST_IDLE;
            end
         end
         dhgm_pkg::ST_ACC_WR: begin
            state_in = fend_ff ? dhgm_pkg::ST_BLD_RD : dhgm_pkg::ST_IDLE;
         end
         dhgm_pkg::ST_BLD_RD:  state_in = dhgm_pkg::ST_BLD_SUM;
         dhgm_pkg::ST_BLD_SUM: state_in = dhgm_pkg::ST_BLD_DIV;
         dhgm_pkg::ST_BLD_DIV: state_in = dhgm_pkg::ST_BLD_WAIT;
         dhgm_pkg::ST_BLD_WAIT: begin
            if (div_status.done) begin
               state_in = (idx_ff == dhgm_pkg::BIN_LAST) ? dhgm_pkg::ST_IDLE
                                                         : dhgm_pkg::ST_BLD_RD;
            end
         end
         dhgm_pkg::ST_MAP_RD:  state_in = dhgm_pkg::ST_MAP_OUT;
         dhgm_pkg::ST_MAP_OUT: state_in = dhgm_pkg::ST_IDLE;
         default:              state_in = dhgm_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      ready_in     = ready_ff;
      point_in     = point_ff;
      cum_in       = cum_ff;
      depth_in     = depth_ff;
      fend_in      = fend_ff;
      rsp_valid_in = 1'b0;
      rsp_gray_in  = rsp_gray_ff;
      rsp_last_in  = rsp_last_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = idx_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = idx_ff;
      mem_wr_data  = '0;
      div_start    = 1'b0;
      case (state_ff)
         dhgm_pkg::ST_CLEAR: begin
            mem_wr_en = 1'b1;
            idx_in    = idx_ff + 1'b1;
         end
         dhgm_pkg::ST_IDLE: begin
            if (accept) begin
               depth_in = req_depth_sample;
               fend_in  = req_frame_end;
               if (req_opcode == dhgm_pkg::OP_ACCUMULATE && ready_ff) begin
                  // new frame: drop the table, sweep the bins first
                  ready_in = 1'b0;
                  point_in = '0;
                  pend_in  = 1'b1;
                  idx_in   = '0;
               end
            end
         end
         dhgm_pkg::ST_ACC_RD: begin
            pend_in     = 1'b0;
            mem_rd_en   = depth_hit;
            mem_rd_addr = depth_ff[dhgm_pkg::BIN_AW-1:0];
            idx_in      = dhgm_pkg::BIN_FIRST;
            cum_in      = '0;
         end
         dhgm_pkg::ST_ACC_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = depth_ff[dhgm_pkg::BIN_AW-1:0];
            mem_wr_data = (rd_data_ff == dhgm_pkg::CNT_MAX) ? rd_data_ff
                                                            : rd_data_ff + 1'b1;
            if (point_ff != dhgm_pkg::CNT_MAX) begin
               point_in = point_ff + 1'b1;
            end
         end
         dhgm_pkg::ST_BLD_RD: begin
            mem_rd_en = 1'b1;
         end
         dhgm_pkg::ST_BLD_SUM: begin
            // running sum clamped to the point count
            cum_in = (sum > {1'b0, point_ff}) ? point_ff : sum[dhgm_pkg::CNT_W-1:0];
         end
         dhgm_pkg::ST_BLD_DIV: begin
            div_start = 1'b1;
         end
         dhgm_pkg::ST_BLD_WAIT: begin
            if (div_status.done) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = dhgm_pkg::CNT_W'(div_status.gray);
               idx_in      = idx_ff + 1'b1;
               if (idx_ff == dhgm_pkg::BIN_LAST) begin
                  ready_in = 1'b1;
               end
            end
         end
         dhgm_pkg::ST_MAP_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = depth_ff[dhgm_pkg::BIN_AW-1:0];
         end
         dhgm_pkg::ST_MAP_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_gray_in  = (ready_ff && depth_hit) ? rd_data_ff[dhgm_pkg::GRAY_W-1:0] : '0;
            rsp_last_in  = fend_ff;
         end
         default: begin
            mem_wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         bin_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= bin_mem[mem_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      cum_ff      <= cum_in;
      depth_ff    <= depth_in;
      fend_ff     <= fend_in;
      rsp_gray_ff <= rsp_gray_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff     <= dhgm_pkg::ST_CLEAR;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         ready_ff     <= 1'b0;
         point_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         ready_ff     <= ready_in;
         point_ff     <= point_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_gray_level    = rsp_gray_ff;
   assign rsp_last_of_frame = rsp_last_ff;

endmodule

FILE: hw/rtl/dhgm_checker.sv
// port-level checks for depth_histogram_gray_mapper, attached by bind
// depends on the top level's ports only
module dhgm_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_opcode,
   input logic [15:0] req_depth_sample,
   input logic        req_frame_end,
   input logic        rsp_valid,
   input logic [7:0]  rsp_gray_level,
   input logic        rsp_last_of_frame
);

   // a beat taken always keeps the block busy for the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   // every response comes from an earlier accepted map beat
   a_rsp_from_map: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && req_opcode, 3))
      else $error("response without a map beat");

   a_rsp_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_of_frame == $past(req_frame_end, 3)))
      else $error("last_of_frame does not follow the map beat");

   a_rsp_zero_depth: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_depth_sample == 16'd0, 3)) |-> (rsp_gray_level == 8'd0))
      else $error("depth zero mapped to nonzero gray");

endmodule

bind depth_histogram_gray_mapper dhgm_checker u_dhgm_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_opcode        (req_opcode),
   .req_depth_sample  (req_depth_sample),
   .req_frame_end     (req_frame_end),
   .rsp_valid         (rsp_valid),
   .rsp_gray_level    (rsp_gray_level),
   .rsp_last_of_frame (rsp_last_of_frame)
);
